[sv/bms_pkg.sv]
// shared codes and control structures for the byte machine step block
package bms_pkg;

  // host function codes
  localparam logic [1:0] FN_WRITE_PROG = 2'd0;
  localparam logic [1:0] FN_WRITE_DATA = 2'd1;
  localparam logic [1:0] FN_READ_DATA  = 2'd2;
  localparam logic [1:0] FN_EXEC       = 2'd3;

  // instruction opcodes
  localparam logic [2:0] OP_LDK  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_LDI  = 3'd2;
  localparam logic [2:0] OP_STI  = 3'd3;
  localparam logic [2:0] OP_ADDZ = 3'd4;
  localparam logic [2:0] OP_SHL  = 3'd5;
  localparam logic [2:0] OP_SWAP = 3'd6;
  localparam logic [2:0] OP_XOR  = 3'd7;

  // data memory read address select
  localparam logic [2:0] RS_HOST = 3'd0;
  localparam logic [2:0] RS_A    = 3'd1;
  localparam logic [2:0] RS_B    = 3'd2;
  localparam logic [2:0] RS_D    = 3'd3;
  localparam logic [2:0] RS_EA   = 3'd4;

  // data memory write select
  localparam logic [2:0] WS_HOST = 3'd0;
  localparam logic [2:0] WS_EXEC = 3'd1;
  localparam logic [2:0] WS_IND  = 3'd2;
  localparam logic [2:0] WS_SWAP = 3'd3;
  localparam logic [2:0] WS_INC  = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic       cap_in;
    logic       prog_wr;
    logic       prog_rd;
    logic       dm_rd;
    logic [2:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       dm_wr;
    logic [2:0] wr_sel;
    logic       out_load;
    logic       out_is_read;
  } bms_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
  } bms_sts_t;

endpackage

[sv/bms_dpath.sv]
// datapath: program store, data memory, operand registers and result register
module bms_dpath (
  input  logic              clk,
  input  logic [7:0]        in_addr,
  input  logic [7:0]        in_data,
  input  bms_pkg::bms_cmd_t cmd,
  output bms_pkg::bms_sts_t sts,
  output logic [7:0]        out_read_data,
  output logic [7:0]        out_ip_now
);

  logic [7:0] prog_mem [256];
  logic [7:0] data_mem [256];

  logic [7:0] addr_r;
  logic [7:0] data_r;
  logic [7:0] ip_r;
  logic [7:0] inst_r;
  logic [7:0] dm_rdata_r;
  logic [7:0] va_r;
  logic [7:0] vb_r;
  logic [7:0] out_read_data_r;
  logic [7:0] out_ip_now_r;

  logic [2:0] op;
  logic       fa;
  logic [1:0] fb;
  logic [1:0] fd;
  logic [3:0] fk;
  logic [7:0] ea;
  logic [7:0] dm_raddr;
  logic [7:0] dm_waddr;
  logic [7:0] dm_wdata;
  logic       dm_we;
  logic [7:0] ex_waddr;
  logic [7:0] ex_wdata;
  logic       ex_ok;

  // instruction fields
  assign op  = inst_r[7:5];
  assign fa  = inst_r[0];
  assign fb  = inst_r[2:1];
  assign fd  = inst_r[4:3];
  assign fk  = inst_r[3:0];
  assign ea  = 8'(va_r + vb_r);
  assign sts.op = op;

  // host transaction fields
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      addr_r <= in_addr;
      data_r <= in_data;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      va_r <= dm_rdata_r;
    end
    if (cmd.cap_b) begin
      vb_r <= dm_rdata_r;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      bms_pkg::RS_HOST: dm_raddr = addr_r;
      bms_pkg::RS_A:    dm_raddr = (op == bms_pkg::OP_SWAP) ? 8'd1 : {7'd0, fa};
      bms_pkg::RS_B:    dm_raddr = (op == bms_pkg::OP_SWAP) ? {4'd0, fk} : {6'd0, fb};
      bms_pkg::RS_D:    dm_raddr = {6'd0, fd};
      bms_pkg::RS_EA:   dm_raddr = ea;
      default:          dm_raddr = addr_r;
    endcase
  end

  // instruction result, dm_rdata_r holds mem[d] in this step
  always_comb begin
    ex_waddr = {6'd0, fd};
    ex_wdata = 8'd0;
    ex_ok    = 1'b1;
    case (op)
      bms_pkg::OP_LDK:  ex_wdata = {4'd0, fk};
      bms_pkg::OP_ADD:  ex_wdata = ea;
      bms_pkg::OP_LDI:  ex_ok    = 1'b0;
      bms_pkg::OP_STI: begin
        ex_waddr = ea;
        ex_wdata = dm_rdata_r;
      end
      bms_pkg::OP_ADDZ: begin
        ex_wdata = 8'(dm_rdata_r + va_r);
        ex_ok    = (vb_r == 8'd0);
      end
      bms_pkg::OP_SHL:  ex_wdata = 8'(va_r << fb);
      bms_pkg::OP_SWAP: begin
        ex_waddr = {4'd0, fk};
        ex_wdata = va_r;
      end
      bms_pkg::OP_XOR:  ex_wdata = va_r ^ vb_r;
      default:          ex_ok    = 1'b0;
    endcase
  end

  // write port select
  always_comb begin
    dm_we = cmd.dm_wr;
    case (cmd.wr_sel)
      bms_pkg::WS_HOST: begin
        dm_waddr = addr_r;
        dm_wdata = data_r;
      end
      bms_pkg::WS_EXEC: begin
        dm_waddr = ex_waddr;
        dm_wdata = ex_wdata;
        dm_we    = cmd.dm_wr & ex_ok;
      end
      bms_pkg::WS_IND: begin
        dm_waddr = {6'd0, fd};
        dm_wdata = dm_rdata_r;
      end
      bms_pkg::WS_SWAP: begin
        dm_waddr = 8'd1;
        dm_wdata = vb_r;
      end
      bms_pkg::WS_INC: begin
        dm_waddr = 8'd0;
        dm_wdata = 8'(ip_r + 8'd1);
      end
      default: begin
        dm_waddr = addr_r;
        dm_wdata = data_r;
        dm_we    = 1'b0;
      end
    endcase
  end

  // program store
  always_ff @(posedge clk) begin
    if (cmd.prog_wr) begin
      prog_mem[addr_r] <= data_r;
    end
    if (cmd.prog_rd) begin
      inst_r <= prog_mem[ip_r];
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    if (cmd.dm_rd) begin
      dm_rdata_r <= data_mem[dm_raddr];
    end
  end

  // shadow copy of byte 0, the instruction pointer
  always_ff @(posedge clk) begin
    if (dm_we && (dm_waddr == 8'd0)) begin
      ip_r <= dm_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data_r <= cmd.out_is_read ? dm_rdata_r : 8'd0;
      out_ip_now_r    <= ip_r;
    end
  end

  assign out_read_data = out_read_data_r;
  assign out_ip_now    = out_ip_now_r;

endmodule

[sv/bms_ctrl.sv]
// controller: sequences host transactions and instruction steps
module bms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  bms_pkg::bms_sts_t sts,
  output bms_pkg::bms_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WPROG = 4'd1;
  localparam logic [3:0] ST_WDATA = 4'd2;
  localparam logic [3:0] ST_RDATA = 4'd3;
  localparam logic [3:0] ST_FETCH = 4'd4;
  localparam logic [3:0] ST_DEC   = 4'd5;
  localparam logic [3:0] ST_OPA   = 4'd6;
  localparam logic [3:0] ST_OPB   = 4'd7;
  localparam logic [3:0] ST_OPD   = 4'd8;
  localparam logic [3:0] ST_IND   = 4'd9;
  localparam logic [3:0] ST_SWAP  = 4'd10;
  localparam logic [3:0] ST_INC   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [1:0] func_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.rd_sel      = bms_pkg::RS_HOST;
    cmd.wr_sel      = bms_pkg::WS_HOST;
    cmd.out_is_read = (func_r == bms_pkg::FN_READ_DATA);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.cap_in = 1'b1;
          case (in_func)
            bms_pkg::FN_WRITE_PROG: state_nxt = ST_WPROG;
            bms_pkg::FN_WRITE_DATA: state_nxt = ST_WDATA;
            bms_pkg::FN_READ_DATA:  state_nxt = ST_RDATA;
            bms_pkg::FN_EXEC:       state_nxt = ST_FETCH;
            default:                state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WPROG: begin
        cmd.prog_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_WDATA: begin
        cmd.dm_wr  = 1'b1;
        cmd.wr_sel = bms_pkg::WS_HOST;
        state_nxt  = ST_DONE;
      end
      ST_RDATA: begin
        cmd.dm_rd  = 1'b1;
        cmd.rd_sel = bms_pkg::RS_HOST;
        state_nxt  = ST_DONE;
      end
      ST_FETCH: begin
        cmd.prog_rd = 1'b1;
        state_nxt   = ST_DEC;
      end
      ST_DEC: begin
        cmd.dm_rd  = 1'b1;
        cmd.rd_sel = bms_pkg::RS_A;
        state_nxt  = ST_OPA;
      end
      ST_OPA: begin
        cmd.cap_a  = 1'b1;
        cmd.dm_rd  = 1'b1;
        cmd.rd_sel = bms_pkg::RS_B;
        state_nxt  = ST_OPB;
      end
      ST_OPB: begin
        cmd.cap_b  = 1'b1;
        cmd.dm_rd  = 1'b1;
        cmd.rd_sel = bms_pkg::RS_D;
        state_nxt  = ST_OPD;
      end
      ST_OPD: begin
        // indirect load reads once more, everything else writes here
        if (sts.op == bms_pkg::OP_LDI) begin
          cmd.dm_rd  = 1'b1;
          cmd.rd_sel = bms_pkg::RS_EA;
          state_nxt  = ST_IND;
        end else begin
          cmd.dm_wr  = 1'b1;
          cmd.wr_sel = bms_pkg::WS_EXEC;
          state_nxt  = (sts.op == bms_pkg::OP_SWAP) ? ST_SWAP : ST_INC;
        end
      end
      ST_IND: begin
        cmd.dm_wr  = 1'b1;
        cmd.wr_sel = bms_pkg::WS_IND;
        state_nxt  = ST_INC;
      end
      ST_SWAP: begin
        cmd.dm_wr  = 1'b1;
        cmd.wr_sel = bms_pkg::WS_SWAP;
        state_nxt  = ST_INC;
      end
      ST_INC: begin
        cmd.dm_wr  = 1'b1;
        cmd.wr_sel = bms_pkg::WS_INC;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // wait for a free result register
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // function of the transaction in progress
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
    end
  end

endmodule

[sv/byte_machine_step_top.sv]
// top level of the byte machine step block, one transaction in flight at a time
// a host write or read passes its own state, then ST_DONE; an instruction steps through
//   FETCH, DEC, OPA, OPB, OPD, INC and DONE, with IND or SWAP before INC for indirect load
//   and swap (one extra data memory access); the steps run in order, as each operand comes
//   from a registered read of the data memory; DONE holds while out_valid and !out_ready
// synchronous active-low reset clears control only; both 256-byte stores have no reset value
module byte_machine_step_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_addr,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [7:0] out_ip_now
);

  bms_pkg::bms_cmd_t cmd;
  bms_pkg::bms_sts_t sts;

  // sequencer
  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores and arithmetic
  bms_dpath u_dpath (
    .clk           (clk),
    .in_addr       (in_addr),
    .in_data       (in_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_read_data (out_read_data),
    .out_ip_now    (out_ip_now)
  );

  // block is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a new result only appears as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (in_ready && out_valid))
    else $error("result loaded without returning to idle");

  // data memory: never read and write in one cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.dm_wr && cmd.dm_rd))
    else $error("data memory read and write in the same cycle");

endmodule
